@@ src/smrs_pkg.sv @@
// Shared widths, operation and status codes, and the stored span type of the range set.
package smrs_pkg;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_RANGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// One held range as kept in the table: base and exclusive end.
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] last_end;
	} span_t;

endpackage

@@ src/smrs_if.sv @@
// Request and response channel interfaces of the range set.
interface smrs_req_if
	import smrs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [ADDR_W-1:0]   range_base;
	logic [ADDR_W-1:0]   range_length;
	logic [IDX_W-1:0]    read_index;

	modport source (output valid, func, range_base, range_length, read_index, input ready);
	modport sink   (input valid, func, range_base, range_length, read_index, output ready);
endinterface

interface smrs_rsp_if
	import smrs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;
	logic [ADDR_W-1:0]   entry_base;
	logic [ADDR_W-1:0]   entry_length;

	modport source (output valid, status, entry_count, entry_base, entry_length, input ready);
	modport sink   (input valid, status, entry_count, entry_base, entry_length, output ready);
endinterface

@@ src/sorted_merged_range_set.sv @@
// Top level of the sorted merged range set: span table memory and insert/read sequencer.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | func, range_base, range_length, read_index
//  rsp     | out | status, entry_count, entry_base, entry_length
//
// Insert into a non-empty table makes one streaming pass over the table memory, one
// entry per cycle through its single read port, except for the step in which the new
// span is taken into the stream in sort order. Insert into an empty table skips the
// pass and folds only the new span. Read addresses the table and registers the entry;
// clear and rejected inserts go straight to the result.
// Reset clears the count; table contents are never cleared, only rewritten.
// A request is taken only while the sequencer is idle; a result waits in the
// output register while the next request is already accepted.
module sorted_merged_range_set
	import smrs_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	smrs_req_if.sink   req,
	smrs_rsp_if.source rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRIME,
		S_PROC,
		S_TAIL,
		S_FLUSH,
		S_RDADDR,
		S_RDDATA,
		S_DONE
	} state_t;

	state_t state_q;

	// table memory and its registered read data
	span_t mem [CAPACITY];
	span_t rd_q;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     w_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] n_base_q;
	logic [ADDR_W-1:0] n_end_q;
	logic              n_used_q;
	logic [ADDR_W-1:0] acc_base_q;
	logic [ADDR_W-1:0] acc_end_q;
	logic              acc_vld_q;

	status_t           res_status_q;
	logic [ADDR_W-1:0] res_base_q;
	logic [ADDR_W-1:0] res_len_q;

	logic              ovld_q;
	status_t           o_status_q;
	logic [COUNT_W-1:0] o_count_q;
	logic [ADDR_W-1:0] o_base_q;
	logic [ADDR_W-1:0] o_len_q;

	logic              x_valid;
	logic              x_is_new;
	span_t             x;
	logic              joins;
	logic              advance;
	logic              more;
	logic [CW-1:0]     i_next;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	span_t             wr_data;
	logic              accept;
	logic              bad_range;
	logic              full;
	logic              idx_ok;
	logic [ADDR_W-1:0] req_end;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign req_end   = req.range_base + req.range_length;
	assign bad_range = (req.range_length == '0) || (req.range_base > ~req.range_length);
	assign full      = (count_q >= CW'(CAPACITY));
	assign idx_ok    = (32'(req.read_index) < 32'(count_q));

	// next span of the merged sorted stream and how it folds into the accumulator
	always_comb begin
		i_next   = i_q + CW'(1);
		x_is_new = !n_used_q && ((state_q == S_TAIL) ||
			(state_q == S_PROC && n_base_q <= rd_q.base));
		x_valid  = (state_q == S_PROC) || (state_q == S_TAIL && !n_used_q);
		x        = x_is_new ? span_t'{base: n_base_q, last_end: n_end_q} : rd_q;
		joins    = acc_vld_q && (x.base <= acc_end_q);
		advance  = (state_q == S_PROC) && !x_is_new;
		more     = (i_next < count_q);

		wr_en    = (x_valid && !joins && acc_vld_q) || (state_q == S_FLUSH);
		wr_addr  = w_q[AW-1:0];
		wr_data  = '{base: acc_base_q, last_end: acc_end_q};

		rd_en    = (state_q == S_PRIME) || (state_q == S_RDADDR) || (advance && more);
		case (state_q)
			S_RDADDR: rd_addr = AW'(idx_q);
			S_PRIME:  rd_addr = '0;
			default:  rd_addr = i_next[AW-1:0];
		endcase
	end

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovld_q    <= 1'b0;
			acc_vld_q <= 1'b0;
			n_used_q  <= 1'b0;
			i_q       <= '0;
			w_q       <= '0;
		end else begin
			// output valid: load a finished result, drop a taken one
			if (state_q == S_DONE && (!ovld_q || rsp.ready)) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end

			// fold the current stream span
			if (x_valid) begin
				if (x_is_new) begin
					n_used_q <= 1'b1;
				end
				if (joins) begin
					if (x.last_end > acc_end_q) begin
						acc_end_q <= x.last_end;
					end
				end else begin
					acc_base_q <= x.base;
					acc_end_q  <= x.last_end;
					acc_vld_q  <= 1'b1;
					if (acc_vld_q) begin
						w_q <= w_q + CW'(1);
					end
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_base_q   <= '0;
						res_len_q    <= '0;
						idx_q        <= req.read_index;
						n_base_q     <= req.range_base;
						n_end_q      <= req_end;
						n_used_q     <= 1'b0;
						acc_vld_q    <= 1'b0;
						i_q          <= '0;
						w_q          <= '0;
						state_q      <= S_DONE;
						case (func_t'(req.func))
							FUNC_INSERT: begin
								if (bad_range) begin
									res_status_q <= ST_BAD_RANGE;
								end else if (full) begin
									res_status_q <= ST_FULL;
								end else if (count_q == '0) begin
									state_q <= S_TAIL;
								end else begin
									state_q <= S_PRIME;
								end
							end
							FUNC_READ: begin
								if (idx_ok) begin
									state_q <= S_RDADDR;
								end else begin
									res_status_q <= ST_BAD_INDEX;
								end
							end
							FUNC_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_PRIME: begin
					state_q <= S_PROC;
				end
				S_PROC: begin
					if (advance) begin
						if (more) begin
							i_q <= i_next;
						end else begin
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					count_q <= w_q + CW'(1);
					state_q <= S_DONE;
				end
				S_RDADDR: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					res_base_q <= rd_q.base;
					res_len_q  <= rd_q.last_end - rd_q.base;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!ovld_q || rsp.ready) begin
						o_status_q <= res_status_q;
						o_count_q  <= COUNT_W'(count_q);
						o_base_q   <= res_base_q;
						o_len_q    <= res_len_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = ovld_q;
	assign rsp.status       = o_status_q;
	assign rsp.entry_count  = o_count_q;
	assign rsp.entry_base   = o_base_q;
	assign rsp.entry_length = o_len_q;

endmodule
